>>> hdl/lfys_pkg.sv
// ----------------------------------------------------------------------------
// lfys_pkg
// Shared types and constants for the seeded shuffle store.
// ----------------------------------------------------------------------------
package lfys_pkg;

    localparam int STORE_DEPTH = 512;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = 10;
    localparam int ELEM_W      = 16;
    localparam int SEED_W      = 32;
    localparam int POS_W       = 9;
    localparam int DRAW_W      = 16;
    localparam int REM_W       = ADDR_W;
    localparam int DIV_W       = ADDR_W + 1;
    localparam int STEP_W      = $clog2(DRAW_W + 1);

    localparam logic [SEED_W-1:0] GEN_MUL = 32'd83409763;
    localparam logic [SEED_W-1:0] GEN_ADD = 32'd1444837343;

    localparam logic [1:0] MODE_CLEAR   = 2'd0;
    localparam logic [1:0] MODE_LOAD    = 2'd1;
    localparam logic [1:0] MODE_SHUFFLE = 2'd2;
    localparam logic [1:0] MODE_READ    = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [1:0]        mode;
        logic [ELEM_W-1:0] element;
        logic [SEED_W-1:0] seed;
        logic [POS_W-1:0]  position;
    } in_beat_t;

    typedef struct packed {
        logic [ELEM_W-1:0] read_value;
        logic [CNT_W-1:0]  element_count;
        logic [1:0]        status;
    } out_beat_t;

    typedef struct packed {
        logic             done;
        logic [REM_W-1:0] rem;
    } mod_res_t;

    typedef struct packed {
        logic              re;
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [ELEM_W-1:0] wdata;
    } store_req_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDATA,
        S_MSTART,
        S_MWAIT,
        S_SWRD,
        S_SWA,
        S_SWB,
        S_RESP
    } state_t;

endpackage

>>> hdl/lfys_mod.sv
// ----------------------------------------------------------------------------
// lfys_mod
// Bit-serial restoring remainder unit: draw mod span, one dividend bit a cycle.
// ----------------------------------------------------------------------------
module lfys_mod (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [lfys_pkg::DRAW_W-1:0]   dividend,
    input  logic [lfys_pkg::DIV_W-1:0]    divisor,
    output lfys_pkg::mod_res_t            res
);

    logic [lfys_pkg::DRAW_W-1:0] dvd_reg;
    logic [lfys_pkg::DIV_W-1:0]  div_reg;
    logic [lfys_pkg::REM_W-1:0]  rem_reg;
    logic [lfys_pkg::STEP_W-1:0] step_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [lfys_pkg::DIV_W-1:0]  trial;
    logic [lfys_pkg::DIV_W-1:0]  trial_sub;

    // The partial remainder stays below the divisor, so the shifted value
    // stays below twice the divisor and fits one extra bit.
    always_comb begin
        trial     = {rem_reg, dvd_reg[lfys_pkg::DRAW_W-1]};
        trial_sub = trial - div_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= lfys_pkg::STEP_W'(lfys_pkg::DRAW_W);
        end else if (busy_reg) begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == lfys_pkg::STEP_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[lfys_pkg::DRAW_W-2:0], 1'b0};
            if (trial >= div_reg) begin
                rem_reg <= trial_sub[lfys_pkg::REM_W-1:0];
            end else begin
                rem_reg <= trial[lfys_pkg::REM_W-1:0];
            end
        end
    end

    assign res.done = done_reg;
    assign res.rem  = rem_reg;

endmodule

>>> hdl/lfys_store.sv
// ----------------------------------------------------------------------------
// lfys_store
// Element memory: one write port and two registered read ports.
// ----------------------------------------------------------------------------
module lfys_store (
    input  logic                        aclk,
    input  lfys_pkg::store_req_t        req,
    output logic [lfys_pkg::ELEM_W-1:0] rdata_a,
    output logic [lfys_pkg::ELEM_W-1:0] rdata_b
);

    logic [lfys_pkg::ELEM_W-1:0] mem [lfys_pkg::STORE_DEPTH];
    logic [lfys_pkg::ELEM_W-1:0] rdata_a_reg;
    logic [lfys_pkg::ELEM_W-1:0] rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Read data holds while no read is issued.
    always_ff @(posedge aclk) begin
        if (req.re) begin
            rdata_a_reg <= mem[req.raddr_a];
            rdata_b_reg <= mem[req.raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

>>> hdl/lcg_fisher_yates_shuffle.sv
// ----------------------------------------------------------------------------
// lcg_fisher_yates_shuffle
// Element store with clear, load, read and a seeded in-place shuffle.
// ----------------------------------------------------------------------------
// Clear and load beats go straight to the response state; read beats pass
// through the read-data state first. A shuffle of n elements, n at least
// two, covers n-1 positions, each set by the bit-serial remainder unit (a
// start, the shifts and a done per draw) and the read-then-two-writes
// swap on the single write port of the element memory. A shuffle of fewer
// than two elements goes straight to the response. The block takes one
// beat at a time. A finished result waits in the output register while the
// next beat is taken in; the result of that beat is held in its last state
// until the register has been emptied.
module lcg_fisher_yates_shuffle (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lfys_pkg::in_beat_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output lfys_pkg::out_beat_t m_payload
);

    lfys_pkg::state_t            state_reg;
    lfys_pkg::state_t            state_next;
    logic [lfys_pkg::CNT_W-1:0]  count_reg;
    logic [lfys_pkg::SEED_W-1:0] gen_reg;
    logic [lfys_pkg::SEED_W-1:0] prod_reg;
    logic [lfys_pkg::ADDR_W-1:0] i_reg;
    logic [lfys_pkg::ADDR_W-1:0] j_reg;
    logic [lfys_pkg::POS_W-1:0]  pos_reg;
    logic [lfys_pkg::ELEM_W-1:0] value_reg;
    logic [1:0]                  status_reg;
    logic                        m_valid_reg;
    lfys_pkg::out_beat_t         m_payload_reg;

    logic                        accept;
    logic                        slot_free;
    logic                        full;
    logic                        pos_ok;
    logic                        more;
    logic                        mod_start;
    logic [lfys_pkg::DIV_W-1:0]  span;
    lfys_pkg::mod_res_t          mod_res;
    lfys_pkg::store_req_t        store_req;
    logic [lfys_pkg::ELEM_W-1:0] rdata_a;
    logic [lfys_pkg::ELEM_W-1:0] rdata_b;

    lfys_mod u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mod_start),
        .dividend (gen_reg[lfys_pkg::SEED_W-1 -: lfys_pkg::DRAW_W]),
        .divisor  (span),
        .res      (mod_res)
    );

    lfys_store u_store (
        .aclk    (aclk),
        .req     (store_req),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    always_comb begin
        accept    = s_valid && s_ready;
        slot_free = !m_valid_reg || m_ready;
        full      = (count_reg >= lfys_pkg::CNT_W'(lfys_pkg::STORE_DEPTH));
        pos_ok    = (lfys_pkg::CNT_W'(pos_reg) < count_reg);
        span      = lfys_pkg::DIV_W'(count_reg - lfys_pkg::CNT_W'(i_reg));
        more      = ((lfys_pkg::CNT_W'(i_reg) + lfys_pkg::CNT_W'(2)) < count_reg);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lfys_pkg::S_IDLE: begin
                if (s_valid) begin
                    case (s_payload.mode)
                        lfys_pkg::MODE_READ: state_next = lfys_pkg::S_RDATA;
                        lfys_pkg::MODE_SHUFFLE: begin
                            if (count_reg >= lfys_pkg::CNT_W'(2)) begin
                                state_next = lfys_pkg::S_MSTART;
                            end else begin
                                state_next = lfys_pkg::S_RESP;
                            end
                        end
                        default: state_next = lfys_pkg::S_RESP;
                    endcase
                end
            end
            lfys_pkg::S_RDATA:  state_next = lfys_pkg::S_RESP;
            lfys_pkg::S_MSTART: state_next = lfys_pkg::S_MWAIT;
            lfys_pkg::S_MWAIT: begin
                if (mod_res.done) begin
                    state_next = lfys_pkg::S_SWRD;
                end
            end
            lfys_pkg::S_SWRD: state_next = lfys_pkg::S_SWA;
            lfys_pkg::S_SWA:  state_next = lfys_pkg::S_SWB;
            lfys_pkg::S_SWB: begin
                if (more) begin
                    state_next = lfys_pkg::S_MSTART;
                end else begin
                    state_next = lfys_pkg::S_RESP;
                end
            end
            lfys_pkg::S_RESP: begin
                if (slot_free) begin
                    state_next = lfys_pkg::S_IDLE;
                end
            end
            default: state_next = lfys_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_ready           = 1'b0;
        mod_start         = 1'b0;
        store_req.re      = 1'b0;
        store_req.raddr_a = i_reg;
        store_req.raddr_b = j_reg;
        store_req.we      = 1'b0;
        store_req.waddr   = i_reg;
        store_req.wdata   = rdata_b;
        case (state_reg)
            lfys_pkg::S_IDLE: begin
                s_ready           = 1'b1;
                store_req.re      = s_valid && (s_payload.mode == lfys_pkg::MODE_READ);
                store_req.raddr_a = s_payload.position[lfys_pkg::ADDR_W-1:0];
                store_req.we      = s_valid && (s_payload.mode == lfys_pkg::MODE_LOAD)
                                    && !full;
                store_req.waddr   = count_reg[lfys_pkg::ADDR_W-1:0];
                store_req.wdata   = s_payload.element;
            end
            lfys_pkg::S_MSTART: mod_start = 1'b1;
            lfys_pkg::S_SWRD:   store_req.re = 1'b1;
            lfys_pkg::S_SWA: begin
                store_req.we    = 1'b1;
                store_req.waddr = i_reg;
                store_req.wdata = rdata_b;
            end
            lfys_pkg::S_SWB: begin
                store_req.we    = 1'b1;
                store_req.waddr = j_reg;
                store_req.wdata = rdata_a;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lfys_pkg::S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept && s_payload.mode == lfys_pkg::MODE_CLEAR) begin
                count_reg <= '0;
            end else if (accept && s_payload.mode == lfys_pkg::MODE_LOAD && !full) begin
                count_reg <= count_reg + 1'b1;
            end
            if (state_reg == lfys_pkg::S_RESP && slot_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            gen_reg    <= s_payload.seed;
            pos_reg    <= s_payload.position;
            i_reg      <= '0;
            value_reg  <= '0;
            if (s_payload.mode == lfys_pkg::MODE_LOAD && full) begin
                status_reg <= lfys_pkg::ST_FULL;
            end else begin
                status_reg <= lfys_pkg::ST_OK;
            end
        end
        if (state_reg == lfys_pkg::S_RDATA) begin
            if (pos_ok) begin
                value_reg <= rdata_a;
            end else begin
                status_reg <= lfys_pkg::ST_RANGE;
            end
        end
        // The product is formed during the draw and the increment added after.
        if (state_reg == lfys_pkg::S_MSTART) begin
            prod_reg <= gen_reg * lfys_pkg::GEN_MUL;
        end
        if (state_reg == lfys_pkg::S_MWAIT && mod_res.done) begin
            j_reg   <= i_reg + mod_res.rem;
            gen_reg <= prod_reg + lfys_pkg::GEN_ADD;
        end
        if (state_reg == lfys_pkg::S_SWB) begin
            i_reg <= i_reg + 1'b1;
        end
        if (state_reg == lfys_pkg::S_RESP && slot_free) begin
            m_payload_reg.read_value    <= value_reg;
            m_payload_reg.element_count <= count_reg;
            m_payload_reg.status        <= status_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule
